// ===== hw/rtl/tnrof_pkg.sv =====
// Shared constants, types and tables for the telnet receive option filter.
package tnrof_pkg;

    localparam int LINES     = 4;
    localparam int LINE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int OPT_COUNT = 256;
    localparam int FLAG_W    = 2;
    localparam int ROW_OPTS  = 16;
    localparam int OPT_LO_W  = $clog2(ROW_OPTS);
    localparam int ROW_SEL_W = BYTE_W - OPT_LO_W;
    localparam int ROW_W     = ROW_OPTS * FLAG_W;
    localparam int ROW_DEPTH = LINES * OPT_COUNT / ROW_OPTS;
    localparam int ROW_AW    = $clog2(ROW_DEPTH);
    localparam int IDX_W     = 4;

    typedef logic [ROW_OPTS-1:0][FLAG_W-1:0] flag_row_t;
    typedef logic [3:0] pstate_t;
    typedef logic [1:0] cmd_t;
    typedef logic [1:0] kind_t;

    localparam pstate_t PS_NORM  = 4'd0;
    localparam pstate_t PS_IAC   = 4'd1;
    localparam pstate_t PS_WILL  = 4'd2;
    localparam pstate_t PS_WONT  = 4'd3;
    localparam pstate_t PS_SKIP  = 4'd4;
    localparam pstate_t PS_CRPAD = 4'd5;
    localparam pstate_t PS_DO    = 4'd6;
    localparam pstate_t PS_SB    = 4'd7;
    localparam pstate_t PS_SBIAC = 4'd8;

    localparam cmd_t CMD_BYTE       = 2'd0;
    localparam cmd_t CMD_CONNECT    = 2'd1;
    localparam cmd_t CMD_DISCONNECT = 2'd2;

    localparam kind_t KIND_DATA   = 2'd0;
    localparam kind_t KIND_REFUSE = 2'd1;
    localparam kind_t KIND_MANTRA = 2'd2;

    localparam logic [BYTE_W-1:0] K_IAC      = 8'hFF;
    localparam logic [BYTE_W-1:0] K_DONT     = 8'hFE;
    localparam logic [BYTE_W-1:0] K_DO       = 8'hFD;
    localparam logic [BYTE_W-1:0] K_WONT     = 8'hFC;
    localparam logic [BYTE_W-1:0] K_WILL     = 8'hFB;
    localparam logic [BYTE_W-1:0] K_SB       = 8'hFA;
    localparam logic [BYTE_W-1:0] K_SE       = 8'hF0;
    localparam logic [BYTE_W-1:0] K_BRK      = 8'hF3;
    localparam logic [BYTE_W-1:0] K_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] K_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] K_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] OPT_BIN    = 8'd0;
    localparam logic [BYTE_W-1:0] OPT_ECHO   = 8'd1;
    localparam logic [BYTE_W-1:0] OPT_SGA    = 8'd3;
    localparam logic [BYTE_W-1:0] OPT_LMODE  = 8'd34;

    localparam logic [FLAG_W-1:0] FLAG_DONT  = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_WONT  = 2'b10;

    localparam logic [IDX_W-1:0] REFUSE_LAST     = 4'd2;
    localparam logic [IDX_W-1:0] REFUSE_DBL_LAST = 4'd3;
    localparam logic [IDX_W-1:0] MANTRA_LAST     = 4'd14;

    function automatic logic [BYTE_W-1:0] mantra_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = K_IAC;
            4'd1:    b = K_WILL;
            4'd2:    b = OPT_LMODE;
            4'd3:    b = K_IAC;
            4'd4:    b = K_WILL;
            4'd5:    b = OPT_SGA;
            4'd6:    b = K_IAC;
            4'd7:    b = K_WILL;
            4'd8:    b = OPT_ECHO;
            4'd9:    b = K_IAC;
            4'd10:   b = K_WILL;
            4'd11:   b = OPT_BIN;
            4'd12:   b = K_IAC;
            4'd13:   b = K_DO;
            4'd14:   b = OPT_BIN;
            default: b = K_NUL;
        endcase
        return b;
    endfunction

    function automatic logic refused_option(input logic [BYTE_W-1:0] opt);
        return opt != OPT_BIN && opt != OPT_ECHO && opt != OPT_SGA && opt != OPT_LMODE;
    endfunction

endpackage

// ===== hw/rtl/tnrof_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module tnrof_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/telnet_receive_option_filter_top.sv =====
// Telnet receive filter: per-line IAC parser, option refusal table, reply generator.
//
//   channel   dir  handshake                  payload
//   item      in   item_valid / item_stall    command, line, in_byte
//   result    out  result_valid / result_stall out_byte, out_route, out_line, out_last
//   config    in   cfg_write                  cfg_data (receive_enable)
//
// Items pass stage s1, then the generator; one word per cycle while not stalled.
// An item with k results holds the generator until all k are sent (refusal 3-4, connect 15).
// A connect clears its line's refusal flags, one RAM row at a time, 16 rows, inputs stalled.
// Flag table read-modify-write is bypassed on back-to-back hits to the same row.
// Reset: all lines disconnected, binary mode, receive_enable all ones.
module telnet_receive_option_filter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tnrof_pkg::LINES-1:0]      cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       command,
    input  logic [tnrof_pkg::LINE_W-1:0]     line,
    input  logic [tnrof_pkg::BYTE_W-1:0]     in_byte,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [tnrof_pkg::BYTE_W-1:0]     out_byte,
    output logic                             out_route,
    output logic [tnrof_pkg::LINE_W-1:0]     out_line,
    output logic                             out_last
);

    logic [tnrof_pkg::LINES-1:0]     enable_reg;

    logic                            s1_valid_reg;
    tnrof_pkg::cmd_t                 s1_cmd_reg;
    logic [tnrof_pkg::LINE_W-1:0]    s1_line_reg;
    logic [tnrof_pkg::BYTE_W-1:0]    s1_byte_reg;

    tnrof_pkg::pstate_t              pstate_reg [tnrof_pkg::LINES];
    logic [tnrof_pkg::LINES-1:0]     text_reg;
    logic [tnrof_pkg::LINES-1:0]     conn_reg;

    logic                            byp_valid_reg;
    logic [tnrof_pkg::ROW_AW-1:0]    byp_addr_reg;
    tnrof_pkg::flag_row_t            byp_data_reg;

    logic                            sweep_busy_reg;
    logic [tnrof_pkg::ROW_SEL_W-1:0] sweep_cnt_reg;
    logic [tnrof_pkg::LINE_W-1:0]    sweep_line_reg;

    logic                            gen_valid_reg;
    tnrof_pkg::kind_t                gen_kind_reg;
    logic [tnrof_pkg::IDX_W-1:0]     gen_idx_reg;
    logic [tnrof_pkg::IDX_W-1:0]     gen_last_reg;
    logic [tnrof_pkg::LINE_W-1:0]    gen_line_reg;
    logic [tnrof_pkg::BYTE_W-1:0]    gen_data_reg;
    logic [tnrof_pkg::BYTE_W-1:0]    gen_verb_reg;
    logic                            gen_dbl_reg;

    logic                            accept;
    logic                            s1_fire;
    logic                            gen_free;
    logic [tnrof_pkg::ROW_AW-1:0]    in_addr;
    logic [tnrof_pkg::ROW_AW-1:0]    s1_addr;
    logic [tnrof_pkg::ROW_AW-1:0]    rd_addr;
    logic [tnrof_pkg::ROW_W-1:0]     rd_data;
    logic                            wr_en;
    logic [tnrof_pkg::ROW_AW-1:0]    wr_addr;
    tnrof_pkg::flag_row_t            wr_row;
    tnrof_pkg::flag_row_t            flags_row;
    tnrof_pkg::flag_row_t            new_row;
    logic [tnrof_pkg::FLAG_W-1:0]    cur_flags;

    tnrof_pkg::pstate_t              ps_next;
    logic                            text_next;
    logic                            conn_next;
    logic                            has_res;
    tnrof_pkg::kind_t                res_kind;
    logic [tnrof_pkg::IDX_W-1:0]     res_last;
    logic [tnrof_pkg::BYTE_W-1:0]    res_data;
    logic [tnrof_pkg::BYTE_W-1:0]    res_verb;
    logic                            res_dbl;
    logic [tnrof_pkg::FLAG_W-1:0]    flag_set;
    logic                            sweep_start;

    assign in_addr = {line, in_byte[tnrof_pkg::BYTE_W-1 -: tnrof_pkg::ROW_SEL_W]};
    assign s1_addr = {s1_line_reg, s1_byte_reg[tnrof_pkg::BYTE_W-1 -: tnrof_pkg::ROW_SEL_W]};

    assign gen_free   = !gen_valid_reg || (!result_stall && gen_idx_reg == gen_last_reg);
    assign s1_fire    = s1_valid_reg && !sweep_busy_reg && (gen_free || !has_res);
    assign item_stall = sweep_busy_reg || (s1_valid_reg && !s1_fire);
    assign accept     = item_valid && !item_stall;

    assign rd_addr   = accept ? in_addr : s1_addr;
    assign flags_row = (byp_valid_reg && byp_addr_reg == s1_addr) ?
                       byp_data_reg : tnrof_pkg::flag_row_t'(rd_data);
    assign cur_flags = flags_row[s1_byte_reg[tnrof_pkg::OPT_LO_W-1:0]];

    always_comb
    begin
        new_row = flags_row;
        new_row[s1_byte_reg[tnrof_pkg::OPT_LO_W-1:0]] = cur_flags | flag_set;
    end

    assign wr_en   = sweep_busy_reg || (s1_fire && flag_set != '0);
    assign wr_addr = sweep_busy_reg ? {sweep_line_reg, sweep_cnt_reg} : s1_addr;
    assign wr_row  = sweep_busy_reg ? '0 : new_row;

    tnrof_ram #(
        .WIDTH (tnrof_pkg::ROW_W),
        .DEPTH (tnrof_pkg::ROW_DEPTH)
    ) u_flags (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (tnrof_pkg::ROW_W'(wr_row)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        tnrof_pkg::pstate_t          st;
        logic [tnrof_pkg::BYTE_W-1:0] b;
        logic                         do_normal;
        logic                         do_refuse;

        st          = pstate_reg[s1_line_reg];
        b           = s1_byte_reg;
        do_normal   = 1'b0;
        do_refuse   = 1'b0;
        ps_next     = st;
        text_next   = text_reg[s1_line_reg];
        conn_next   = conn_reg[s1_line_reg];
        has_res     = 1'b0;
        res_kind    = tnrof_pkg::KIND_DATA;
        res_last    = '0;
        res_data    = b;
        res_verb    = tnrof_pkg::K_DONT;
        res_dbl     = 1'b0;
        flag_set    = '0;
        sweep_start = 1'b0;

        case (s1_cmd_reg)
            tnrof_pkg::CMD_BYTE:
            begin
                if (conn_reg[s1_line_reg] && enable_reg[s1_line_reg])
                begin
                    case (st)
                        tnrof_pkg::PS_NORM:
                        begin
                            do_normal = 1'b1;
                        end
                        tnrof_pkg::PS_IAC:
                        begin
                            ps_next = tnrof_pkg::PS_NORM;
                            if (b == tnrof_pkg::K_IAC)
                            begin
                                has_res = 1'b1;
                            end
                            else if (b == tnrof_pkg::K_BRK)
                            begin
                                has_res  = 1'b1;
                                res_data = tnrof_pkg::K_NUL;
                            end
                            else if (b == tnrof_pkg::K_WILL)
                            begin
                                ps_next = tnrof_pkg::PS_WILL;
                            end
                            else if (b == tnrof_pkg::K_WONT)
                            begin
                                ps_next = tnrof_pkg::PS_WONT;
                            end
                            else if (b == tnrof_pkg::K_DO)
                            begin
                                ps_next = tnrof_pkg::PS_DO;
                            end
                            else if (b == tnrof_pkg::K_DONT)
                            begin
                                ps_next = tnrof_pkg::PS_SKIP;
                            end
                            else if (b == tnrof_pkg::K_SB)
                            begin
                                ps_next = tnrof_pkg::PS_SB;
                            end
                        end
                        tnrof_pkg::PS_SB:
                        begin
                            if (b == tnrof_pkg::K_IAC)
                            begin
                                ps_next = tnrof_pkg::PS_SBIAC;
                            end
                        end
                        tnrof_pkg::PS_SBIAC:
                        begin
                            ps_next = (b == tnrof_pkg::K_SE) ?
                                      tnrof_pkg::PS_NORM : tnrof_pkg::PS_SB;
                        end
                        tnrof_pkg::PS_WILL, tnrof_pkg::PS_WONT:
                        begin
                            if (st == tnrof_pkg::PS_WILL && tnrof_pkg::refused_option(b)
                                && !cur_flags[0])
                            begin
                                do_refuse = 1'b1;
                                res_verb  = tnrof_pkg::K_DONT;
                                flag_set  = tnrof_pkg::FLAG_DONT;
                            end
                            if (b == tnrof_pkg::OPT_BIN)
                            begin
                                text_next = (st == tnrof_pkg::PS_WONT);
                            end
                            ps_next = tnrof_pkg::PS_NORM;
                        end
                        tnrof_pkg::PS_CRPAD:
                        begin
                            ps_next   = tnrof_pkg::PS_NORM;
                            do_normal = (b != tnrof_pkg::K_LF) && (b != tnrof_pkg::K_NUL);
                        end
                        tnrof_pkg::PS_DO:
                        begin
                            if (tnrof_pkg::refused_option(b) && !cur_flags[1])
                            begin
                                do_refuse = 1'b1;
                                res_verb  = tnrof_pkg::K_WONT;
                                flag_set  = tnrof_pkg::FLAG_WONT;
                            end
                            ps_next = tnrof_pkg::PS_NORM;
                        end
                        default:
                        begin
                            ps_next = tnrof_pkg::PS_NORM;
                        end
                    endcase

                    if (do_normal)
                    begin
                        if (b == tnrof_pkg::K_IAC)
                        begin
                            ps_next = tnrof_pkg::PS_IAC;
                        end
                        else
                        begin
                            if (b == tnrof_pkg::K_CR && text_reg[s1_line_reg])
                            begin
                                ps_next = tnrof_pkg::PS_CRPAD;
                            end
                            has_res = 1'b1;
                        end
                    end

                    if (do_refuse)
                    begin
                        has_res  = 1'b1;
                        res_kind = tnrof_pkg::KIND_REFUSE;
                        res_dbl  = (b == tnrof_pkg::K_IAC);
                        res_last = res_dbl ? tnrof_pkg::REFUSE_DBL_LAST : tnrof_pkg::REFUSE_LAST;
                    end
                end
            end
            tnrof_pkg::CMD_CONNECT:
            begin
                if (!conn_reg[s1_line_reg])
                begin
                    conn_next   = 1'b1;
                    ps_next     = tnrof_pkg::PS_NORM;
                    text_next   = 1'b0;
                    has_res     = 1'b1;
                    res_kind    = tnrof_pkg::KIND_MANTRA;
                    res_last    = tnrof_pkg::MANTRA_LAST;
                    sweep_start = 1'b1;
                end
            end
            tnrof_pkg::CMD_DISCONNECT:
            begin
                conn_next = 1'b0;
                ps_next   = tnrof_pkg::PS_NORM;
                text_next = 1'b0;
            end
            default:
            begin
                ps_next = st;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= '1;
            s1_valid_reg   <= 1'b0;
            text_reg       <= '0;
            conn_reg       <= '0;
            byp_valid_reg  <= 1'b0;
            sweep_busy_reg <= 1'b0;
            sweep_cnt_reg  <= '0;
            gen_valid_reg  <= 1'b0;
            gen_idx_reg    <= '0;
            for (int i = 0; i < tnrof_pkg::LINES; i++)
            begin
                pstate_reg[i] <= tnrof_pkg::PS_NORM;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                enable_reg <= cfg_data;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                pstate_reg[s1_line_reg] <= ps_next;
                text_reg[s1_line_reg]   <= text_next;
                conn_reg[s1_line_reg]   <= conn_next;
            end

            if (wr_en)
            begin
                byp_valid_reg <= 1'b1;
            end

            if (s1_fire && sweep_start)
            begin
                sweep_busy_reg <= 1'b1;
                sweep_cnt_reg  <= '0;
            end
            else if (sweep_busy_reg)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                if (sweep_cnt_reg == '1)
                begin
                    sweep_busy_reg <= 1'b0;
                end
            end

            if (s1_fire && has_res)
            begin
                gen_valid_reg <= 1'b1;
                gen_idx_reg   <= '0;
            end
            else if (result_valid && !result_stall)
            begin
                if (gen_idx_reg == gen_last_reg)
                begin
                    gen_valid_reg <= 1'b0;
                end
                else
                begin
                    gen_idx_reg <= gen_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= tnrof_pkg::cmd_t'(command);
            s1_line_reg <= line;
            s1_byte_reg <= in_byte;
        end
        if (wr_en)
        begin
            byp_addr_reg <= wr_addr;
            byp_data_reg <= wr_row;
        end
        if (s1_fire && sweep_start)
        begin
            sweep_line_reg <= s1_line_reg;
        end
        if (s1_fire && has_res)
        begin
            gen_kind_reg <= res_kind;
            gen_last_reg <= res_last;
            gen_line_reg <= s1_line_reg;
            gen_data_reg <= res_data;
            gen_verb_reg <= res_verb;
            gen_dbl_reg  <= res_dbl;
        end
    end

    always_comb
    begin
        case (gen_kind_reg)
            tnrof_pkg::KIND_DATA:
            begin
                out_byte = gen_data_reg;
            end
            tnrof_pkg::KIND_REFUSE:
            begin
                case (gen_idx_reg)
                    4'd0:    out_byte = tnrof_pkg::K_IAC;
                    4'd1:    out_byte = gen_verb_reg;
                    4'd2:    out_byte = gen_dbl_reg ? tnrof_pkg::K_IAC : gen_data_reg;
                    default: out_byte = gen_data_reg;
                endcase
            end
            tnrof_pkg::KIND_MANTRA:
            begin
                out_byte = tnrof_pkg::mantra_byte(gen_idx_reg);
            end
            default:
            begin
                out_byte = gen_data_reg;
            end
        endcase
    end

    assign result_valid = gen_valid_reg;
    assign out_route    = (gen_kind_reg != tnrof_pkg::KIND_DATA);
    assign out_line     = gen_line_reg;
    assign out_last     = (gen_idx_reg == gen_last_reg);

endmodule

// ===== hw/rtl/tnrof_checker.sv =====
// Port-level checker for the telnet receive option filter, bound to the top level.
module tnrof_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_write,
    input logic [tnrof_pkg::LINES-1:0]      cfg_data,
    input logic                             item_valid,
    input logic                             item_stall,
    input logic [1:0]                       command,
    input logic [tnrof_pkg::LINE_W-1:0]     line,
    input logic [tnrof_pkg::BYTE_W-1:0]     in_byte,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic [tnrof_pkg::BYTE_W-1:0]     out_byte,
    input logic                             out_route,
    input logic [tnrof_pkg::LINE_W-1:0]     out_line,
    input logic                             out_last
);

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_byte)
            && $stable(out_route) && $stable(out_line) && $stable(out_last))
        else $error("stalled result word changed");

    // terminal data is always a single word
    a_data_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_route |-> out_last)
        else $error("data word not marked last");

    // reply bursts run without gaps on one line
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !out_last |=> result_valid && out_route
            && out_line == $past(out_line))
        else $error("reply burst broken");

    // a reply burst never starts with anything but IAC
    a_burst_head: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && out_last |=> !result_valid || !out_route
            || out_byte == tnrof_pkg::K_IAC)
        else $error("reply burst does not open with IAC");

endmodule

bind telnet_receive_option_filter_top tnrof_checker u_tnrof_checker (.*);
